>>> rtl/ogdf_pkg.sv
// shared types, constants and helpers for the ogg page deframer
`default_nettype none

package ogdf_pkg;

	localparam int MAX_SEGMENTS = 255;
	localparam int SEG_W        = 8;
	localparam int HDR_POS_W    = 5;
	localparam int CAPTURE_LEN  = 4;
	localparam int HDR_CNT_POS  = 26;
	localparam logic [7:0] LACE_FULL = 8'hFF;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_HALT  = 2'd1,
		ST_TRUNC = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_of_body;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       packet_end;
		status_t    status;
	} out_beat_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take;
		logic clear;
		logic page_done;
		logic adv_rd;
		logic adv_skip;
		logic adv_load;
		logic emit_marker;
		logic emit_trunc;
	} dfr_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic halted;
		logic last;
		logic need_adv;
		logic pos_end;
		logic rd_zero;
		logic packet_open;
		logic trunc_needed;
		logic out_free;
	} dfr_stat_t;

	// "OggS"
	function automatic logic [7:0] capture_byte(input logic [1:0] idx);
		logic [7:0] val;
		case (idx)
			2'd0: val = 8'h4F;
			2'd1: val = 8'h67;
			2'd2: val = 8'h67;
			2'd3: val = 8'h53;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ogg_page_packet_deframer.sv
// top level of the ogg page deframer: controller plus datapath
`default_nettype none

// Usage:
//  src channel: one beat per body byte (in_byte, last_of_body). A beat is
//  taken when src_valid is high and src_stall is low.
//  dst channel: one beat per result (payload byte, bare end marker or
//  status word). Taken when dst_valid is high and dst_stall is low.
//  Timing: a payload or halt beat is in the output register in the cycle after
//  its input beat; end markers and truncation status follow the walk below.
//  Flow: header, lacing and payload bytes are taken back to back while the
//  controller accepts. After the last lacing byte and after the last byte
//  of every payload segment the controller walks the lacing table, with a
//  memory read state and a check state per entry visited and a final read
//  once the page has no segments left, so each zero-length segment in a run
//  adds a read and a check to the walk. A beat with last_of_body adds a
//  finishing state, in which a truncation status beat is sent if the body
//  stopped inside a page or an open packet; a body that ends while already halted needs none.
//  Reset: arst_n clears the parse state and the output register; the lacing
//  table holds nothing until the next page writes it, with no clearing pass.
//  Stall: while a beat waits under dst_stall, src_stall is high and the walk
//  and the finish hold before any beat they would send.
module ogg_page_packet_deframer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_stall,
	input  wire ogdf_pkg::in_beat_t  src_beat,
	output logic                     dst_valid,
	input  wire logic                dst_stall,
	output ogdf_pkg::out_beat_t      dst_beat
);

	// command and status between the two halves
	ogdf_pkg::dfr_cmd_t  cmd;
	ogdf_pkg::dfr_stat_t stat;

	// sequencing: byte acceptance, lacing walk, end-of-body finish
	ogdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// parse registers, lacing table and the output register
	ogdf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_beat  (src_beat),
		.dst_stall (dst_stall),
		.cmd       (cmd),
		.stat      (stat),
		.dst_valid (dst_valid),
		.dst_beat  (dst_beat)
	);

endmodule

`default_nettype wire

>>> rtl/ogdf_datapath.sv
// parse registers, lacing table memory and output register of the deframer
`default_nettype none

module ogdf_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ogdf_pkg::in_beat_t src_beat,
	input  wire logic               dst_stall,
	input  wire ogdf_pkg::dfr_cmd_t cmd,
	output ogdf_pkg::dfr_stat_t     stat,
	output logic                    dst_valid,
	output ogdf_pkg::out_beat_t     dst_beat
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LACING,
		PH_PAYLOAD
	} phase_t;

	phase_t                              phase_q;
	logic [ogdf_pkg::HDR_POS_W-1:0]      hdr_pos_q;
	logic [ogdf_pkg::SEG_W-1:0]          seg_cnt_q;
	logic [ogdf_pkg::SEG_W-1:0]          seg_pos_q;
	logic [7:0]                          bytes_left_q;
	logic [7:0]                          cur_len_q;
	logic                                pkt_open_q;
	logic                                halted_q;
	logic [7:0]                          rd_q;
	logic [7:0]                          lace_mem [ogdf_pkg::MAX_SEGMENTS];
	logic                                out_valid_q;
	ogdf_pkg::out_beat_t                 out_q;

	logic [7:0]                          in_b;
	logic                                active;
	logic [7:0]                          bl_next;
	logic [ogdf_pkg::SEG_W:0]            seg_inc_w;
	logic                                lace_done;
	logic                                hdr_match;
	logic                                count_bad;
	logic                                in_capture;
	logic                                pay_end;
	logic                                take_halt;
	logic                                take_pay;
	logic                                emit_any;
	ogdf_pkg::out_beat_t                 next_beat;

	assign in_b       = src_beat.in_byte;
	assign active     = cmd.take && !halted_q;
	assign bl_next    = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : 8'd0;
	assign seg_inc_w  = {1'b0, seg_pos_q} + (ogdf_pkg::SEG_W+1)'(1);
	assign lace_done  = seg_inc_w >= {1'b0, seg_cnt_q};
	assign hdr_match  = in_b == ogdf_pkg::capture_byte(hdr_pos_q[1:0]);
	assign count_bad  = {1'b0, in_b} > 9'(ogdf_pkg::MAX_SEGMENTS);
	assign in_capture = hdr_pos_q < ogdf_pkg::HDR_POS_W'(ogdf_pkg::CAPTURE_LEN);
	assign pay_end    = (bl_next == 8'd0) && (cur_len_q != ogdf_pkg::LACE_FULL);

	assign take_halt = active && (phase_q == PH_HEADER)
		&& ((in_capture && !hdr_match)
		|| (hdr_pos_q == ogdf_pkg::HDR_POS_W'(ogdf_pkg::HDR_CNT_POS) && count_bad));
	assign take_pay  = active && (phase_q == PH_PAYLOAD);
	assign emit_any  = take_halt || take_pay || cmd.emit_marker || cmd.emit_trunc;

	always_comb begin
		next_beat = '{out_byte: 8'd0, byte_valid: 1'b0, packet_end: 1'b0,
			status: ogdf_pkg::ST_OK};
		if (take_halt) begin
			next_beat.status = ogdf_pkg::ST_HALT;
		end else if (take_pay) begin
			next_beat.out_byte   = in_b;
			next_beat.byte_valid = 1'b1;
			next_beat.packet_end = pay_end;
		end else if (cmd.emit_marker) begin
			next_beat.packet_end = 1'b1;
		end else if (cmd.emit_trunc) begin
			next_beat.status = ogdf_pkg::ST_TRUNC;
		end
	end

	always_comb begin
		stat.halted       = halted_q;
		stat.last         = src_beat.last_of_body;
		stat.need_adv     = !halted_q && (((phase_q == PH_LACING) && lace_done)
			|| ((phase_q == PH_PAYLOAD) && (bl_next == 8'd0)));
		stat.pos_end      = seg_pos_q >= seg_cnt_q;
		stat.rd_zero      = rd_q == 8'd0;
		stat.packet_open  = pkt_open_q;
		stat.trunc_needed = !halted_q
			&& ((phase_q != PH_HEADER) || (hdr_pos_q != '0) || pkt_open_q);
		stat.out_free     = !out_valid_q || !dst_stall;
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_pos_q    <= '0;
			seg_cnt_q    <= '0;
			seg_pos_q    <= '0;
			bytes_left_q <= '0;
			cur_len_q    <= '0;
			pkt_open_q   <= 1'b0;
			halted_q     <= 1'b0;
		end else if (cmd.clear) begin
			phase_q      <= PH_HEADER;
			hdr_pos_q    <= '0;
			seg_cnt_q    <= '0;
			seg_pos_q    <= '0;
			bytes_left_q <= '0;
			pkt_open_q   <= 1'b0;
			halted_q     <= 1'b0;
		end else begin
			if (active) begin
				case (phase_q)
					PH_HEADER: begin
						if (in_capture) begin
							if (!hdr_match) begin
								halted_q <= 1'b1;
							end else begin
								hdr_pos_q <= hdr_pos_q + ogdf_pkg::HDR_POS_W'(1);
							end
						end else if (hdr_pos_q
								< ogdf_pkg::HDR_POS_W'(ogdf_pkg::HDR_CNT_POS)) begin
							hdr_pos_q <= hdr_pos_q + ogdf_pkg::HDR_POS_W'(1);
						end else if (count_bad) begin
							halted_q <= 1'b1;
						end else begin
							seg_cnt_q <= in_b;
							seg_pos_q <= '0;
							hdr_pos_q <= '0;
							phase_q   <= (in_b == 8'd0) ? PH_HEADER : PH_LACING;
						end
					end
					PH_LACING: begin
						seg_pos_q <= lace_done ? '0 : seg_inc_w[ogdf_pkg::SEG_W-1:0];
					end
					PH_PAYLOAD: begin
						pkt_open_q   <= !pay_end;
						bytes_left_q <= bl_next;
						if (bl_next == 8'd0) begin
							seg_pos_q <= seg_inc_w[ogdf_pkg::SEG_W-1:0];
						end
					end
					default: begin
						phase_q <= PH_HEADER;
					end
				endcase
			end
			if (cmd.page_done) begin
				phase_q      <= PH_HEADER;
				hdr_pos_q    <= '0;
				seg_pos_q    <= '0;
				bytes_left_q <= '0;
			end
			if (cmd.adv_skip) begin
				seg_pos_q  <= seg_inc_w[ogdf_pkg::SEG_W-1:0];
				pkt_open_q <= 1'b0;
			end
			if (cmd.adv_load) begin
				phase_q      <= PH_PAYLOAD;
				bytes_left_q <= rd_q;
				cur_len_q    <= rd_q;
			end
		end
	end

	// lacing table, registered read
	always_ff @(posedge clk) begin
		if (active && (phase_q == PH_LACING)) begin
			lace_mem[seg_pos_q] <= in_b;
		end
		if (cmd.adv_rd) begin
			rd_q <= lace_mem[seg_pos_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_any) begin
			out_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			out_q <= next_beat;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_beat  = out_q;

	a_seg_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seg_pos_q <= seg_cnt_q)
		else $error("segment position past segment count");

	a_lacing_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LACING) |-> (seg_cnt_q != '0))
		else $error("lacing phase with zero segment count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dst_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled output beat changed");

endmodule

`default_nettype wire

>>> rtl/ogdf_ctrl.sv
// controller state machine of the ogg page deframer
`default_nettype none

module ogdf_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_stall,
	input  wire ogdf_pkg::dfr_stat_t stat,
	output ogdf_pkg::dfr_cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_ADV_RD,
		ST_ADV_CHK,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   take;

	assign src_stall = !((state_q == ST_ACCEPT) && stat.out_free);
	assign take      = src_valid && !src_stall;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_ACCEPT: begin
				cmd.take  = take;
				cmd.clear = take && stat.halted && stat.last;
			end
			ST_ADV_RD: begin
				cmd.page_done = stat.pos_end;
				cmd.adv_rd    = !stat.pos_end;
			end
			ST_ADV_CHK: begin
				if (!stat.rd_zero) begin
					cmd.adv_load = 1'b1;
				end else if (!stat.packet_open) begin
					cmd.adv_skip = 1'b1;
				end else if (stat.out_free) begin
					cmd.adv_skip    = 1'b1;
					cmd.emit_marker = 1'b1;
				end
			end
			ST_FIN: begin
				if (!stat.trunc_needed) begin
					cmd.clear = 1'b1;
				end else if (stat.out_free) begin
					cmd.emit_trunc = 1'b1;
					cmd.clear      = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_ACCEPT: begin
					if (take && !(stat.halted && stat.last)) begin
						if (stat.need_adv) begin
							state_q <= ST_ADV_RD;
							last_q  <= stat.last;
						end else if (stat.last) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_ADV_RD: begin
					if (stat.pos_end) begin
						state_q <= last_q ? ST_FIN : ST_ACCEPT;
					end else begin
						state_q <= ST_ADV_CHK;
					end
				end
				ST_ADV_CHK: begin
					if (!stat.rd_zero) begin
						state_q <= last_q ? ST_FIN : ST_ACCEPT;
					end else if (!stat.packet_open || stat.out_free) begin
						state_q <= ST_ADV_RD;
					end
				end
				ST_FIN: begin
					if (!stat.trunc_needed || stat.out_free) begin
						state_q <= ST_ACCEPT;
					end
				end
				default: begin
					state_q <= ST_ACCEPT;
				end
			endcase
		end
	end

	a_chk_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV_CHK) |-> ($past(state_q) == ST_ADV_RD
		|| $past(state_q) == ST_ADV_CHK))
		else $error("lacing check without a preceding read");

	a_marker_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_marker |-> stat.out_free)
		else $error("end marker issued while output register is occupied");

	a_fin_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !stat.trunc_needed) |=> (state_q == ST_ACCEPT))
		else $error("finish did not return to accept");

endmodule

`default_nettype wire
